// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clk_i, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/lpmrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmrt_pkg
// Shared types, codes and helpers of the IPv4 longest-prefix route table.
// ----------------------------------------------------------------------------
package lpmrt_pkg;

  localparam int MtuW = 14;
  localparam int LenW = 6;
  localparam logic [MtuW-1:0] MtuReset = 14'd1500;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_DEL    = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_FOUND  = 2'd1,
    STAT_TABLE_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [7:0]  device;
    logic [47:0] mac;
    logic [31:0] mask;
    logic [31:0] network;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic cmp_en;
    logic commit;
  } seq_ctl_t;

  localparam logic [2:0] NibPop [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  function automatic logic [LenW-1:0] pop32(input logic [31:0] v);
    logic [LenW-1:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, NibPop[v[4*k +: 4]]};
    end
    return n;
  endfunction

endpackage

// ===== hdl/lpmrt_entry_mem.sv =====
// ----------------------------------------------------------------------------
// lpmrt_entry_mem
// Route entry storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpmrt_entry_mem #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  lpmrt_pkg::entry_t     wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output lpmrt_pkg::entry_t     rdata_o
);
  import lpmrt_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lpmrt_match_unit.sv =====
// ----------------------------------------------------------------------------
// lpmrt_match_unit
// Shared compare unit: checks one entry per cycle and keeps the best one.
// ----------------------------------------------------------------------------
module lpmrt_match_unit #(
  parameter int IdxW = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpmrt_pkg::seq_ctl_t        ctl_i,
  input  logic [1:0]                 op_i,
  input  logic [31:0]                addr_i,
  input  logic [31:0]                mask_i,
  input  lpmrt_pkg::entry_t          entry_i,
  input  logic                       entry_vld_i,
  input  logic [IdxW-1:0]            entry_age_i,
  input  logic [IdxW-1:0]            entry_idx_i,
  output logic                       found_o,
  output logic [IdxW-1:0]            idx_o,
  output logic [IdxW-1:0]            age_o,
  output logic [lpmrt_pkg::LenW-1:0] len_o,
  output logic [47:0]                mac_o,
  output logic [7:0]                 dev_o
);
  import lpmrt_pkg::*;

  logic            found_q, found_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] age_q, age_d;
  logic [LenW-1:0] len_q, len_d;
  logic [47:0]     mac_q, mac_d;
  logic [7:0]      dev_q, dev_d;

  logic [LenW-1:0] len;
  logic            younger;
  logic            take;

  assign len     = pop32(entry_i.mask);
  assign younger = !found_q || (entry_age_i < age_q);

  always_comb begin
    take = 1'b0;
    case (op_i)
      FUNC_ADD: begin
        take = !entry_vld_i && !found_q;
      end
      FUNC_DEL: begin
        take = entry_vld_i && (entry_i.network == addr_i) && (entry_i.mask == mask_i) &&
               younger;
      end
      FUNC_LOOKUP: begin
        take = entry_vld_i && ((addr_i & entry_i.mask) == entry_i.network) &&
               (!found_q || (len > len_q) || ((len == len_q) && younger));
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    age_d   = age_q;
    len_d   = len_q;
    mac_d   = mac_q;
    dev_d   = dev_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
    end else if (ctl_i.cmp_en && take) begin
      found_d = 1'b1;
      idx_d   = entry_idx_i;
      age_d   = entry_age_i;
      len_d   = len;
      mac_d   = entry_i.mac;
      dev_d   = entry_i.device;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    age_q <= age_d;
    len_q <= len_d;
    mac_q <= mac_d;
    dev_q <= dev_d;
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign age_o   = age_q;
  assign len_o   = len_q;
  assign mac_o   = mac_q;
  assign dev_o   = dev_q;

endmodule

// ===== hdl/lpmrt_seq.sv =====
// ----------------------------------------------------------------------------
// lpmrt_seq
// Sequencer: takes a transaction, sweeps all entries, then commits.
// ----------------------------------------------------------------------------
module lpmrt_seq #(
  parameter int Routes = 16,
  parameter int IdxW   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic                 out_free_i,
  output logic                 in_ready_o,
  output lpmrt_pkg::seq_ctl_t  ctl_o,
  output logic [IdxW-1:0]      rd_addr_o,
  output logic [IdxW-1:0]      cmp_idx_o
);
  import lpmrt_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Routes - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            cmp_en_q, cmp_en_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == LastIdx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    ctl_o.clear  = 1'b0;
    ctl_o.commit = 1'b0;
    ctl_o.cmp_en = cmp_en_q;
    cnt_d        = cnt_q;
    cmp_en_d     = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctl_o.clear = in_fire_i;
        cnt_d       = '0;
      end
      ST_SCAN: begin
        cnt_d     = cnt_q + 1'b1;
        cmp_en_d  = 1'b1;
        cmp_idx_d = cnt_q;
      end
      ST_COMMIT: begin
        ctl_o.commit = out_free_i;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      cmp_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cmp_en_q <= cmp_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
  end

  assign rd_addr_o    = cnt_q;
  assign cmp_idx_o    = cmp_idx_q;

endmodule

// ===== hdl/ipv4_lpm_route_table.sv =====
// A transaction passes the scan, drain and commit states before its result is sent.
// A new transaction waits until the last one commits; the single compare unit reads one
//   entry per cycle from the entry memory read port and sweeps the whole table.
// The result register frees the slave side while a result waits to be taken.
// Reset: all entries invalid, ages zero, route MTU 1500; entry data is not cleared.
// ----------------------------------------------------------------------------
// ipv4_lpm_route_table
// IPv4 route table with add, delete and longest-prefix lookup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4_lpm_route_table #(
  parameter int ROUTES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [13:0]  cfg_wdata_i,      // route_mtu
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,     // address, net_mask, hop_mac, device
  input  logic [1:0]   s_axis_tuser,     // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,     // match_mac, match_device, match_mtu,
                                         // prefix_length, zero pad
  output logic [1:0]   m_axis_tuser      // status
);
  import lpmrt_pkg::*;

  localparam int IdxW = (ROUTES > 1) ? $clog2(ROUTES) : 1;

  logic            in_fire;
  logic            out_free;
  seq_ctl_t        ctl;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] cmp_idx;

  logic [1:0]      op_q;
  logic [31:0]     addr_q;
  logic [31:0]     mask_q;
  logic [47:0]     mac_q;
  logic [7:0]      dev_q;
  logic [MtuW-1:0] mtu_q;

  logic [ROUTES-1:0] valid_q;
  logic [IdxW-1:0]   age_q [ROUTES];

  entry_t          wr_entry;
  entry_t          rd_entry;
  logic            mem_we;

  logic            found;
  logic [IdxW-1:0] best_idx;
  logic [IdxW-1:0] best_age;
  logic [LenW-1:0] best_len;
  logic [47:0]     best_mac;
  logic [7:0]      best_dev;

  logic            out_vld_q, out_vld_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [47:0]     out_mac_q, out_mac_d;
  logic [7:0]      out_dev_q, out_dev_d;
  logic [MtuW-1:0] out_mtu_q, out_mtu_d;
  logic [LenW-1:0] out_len_q, out_len_d;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  lpmrt_seq #(
    .Routes (ROUTES),
    .IdxW   (IdxW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctl_o      (ctl),
    .rd_addr_o  (rd_addr),
    .cmp_idx_o  (cmp_idx)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= s_axis_tuser;
      addr_q <= s_axis_tdata[31:0];
      mask_q <= s_axis_tdata[63:32];
      mac_q  <= s_axis_tdata[111:64];
      dev_q  <= s_axis_tdata[119:112];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= MtuReset;
    end else if (cfg_we_i) begin
      mtu_q <= cfg_wdata_i;
    end
  end

  assign wr_entry.network = addr_q;
  assign wr_entry.mask    = mask_q;
  assign wr_entry.mac     = mac_q;
  assign wr_entry.device  = dev_q;
  assign mem_we           = ctl.commit && (op_q == FUNC_ADD) && found;

  lpmrt_entry_mem #(
    .Depth (ROUTES),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (best_idx),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  lpmrt_match_unit #(
    .IdxW (IdxW)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .op_i        (op_q),
    .addr_i      (addr_q),
    .mask_i      (mask_q),
    .entry_i     (rd_entry),
    .entry_vld_i (valid_q[cmp_idx]),
    .entry_age_i (age_q[cmp_idx]),
    .entry_idx_i (cmp_idx),
    .found_o     (found),
    .idx_o       (best_idx),
    .age_o       (best_age),
    .len_o       (best_len),
    .mac_o       (best_mac),
    .dev_o       (best_dev)
  );

  // age 0 is the newest entry; ages of valid entries stay distinct
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ROUTES; i++) begin
        age_q[i] <= '0;
      end
    end else if (ctl.commit && found) begin
      if (op_q == FUNC_ADD) begin
        for (int i = 0; i < ROUTES; i++) begin
          if (IdxW'(i) == best_idx) begin
            valid_q[i] <= 1'b1;
            age_q[i]   <= '0;
          end else if (valid_q[i]) begin
            age_q[i] <= age_q[i] + 1'b1;
          end
        end
      end else if (op_q == FUNC_DEL) begin
        for (int i = 0; i < ROUTES; i++) begin
          if (IdxW'(i) == best_idx) begin
            valid_q[i] <= 1'b0;
            age_q[i]   <= '0;
          end else if (valid_q[i] && (age_q[i] > best_age)) begin
            age_q[i] <= age_q[i] - 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_mac_d    = out_mac_q;
    out_dev_d    = out_dev_q;
    out_mtu_d    = out_mtu_q;
    out_len_d    = out_len_q;
    if (ctl.commit) begin
      out_vld_d    = 1'b1;
      out_status_d = STAT_NOT_FOUND;
      out_mac_d    = '0;
      out_dev_d    = '0;
      out_mtu_d    = '0;
      out_len_d    = '0;
      case (op_q)
        FUNC_ADD: begin
          out_status_d = found ? STAT_OK : STAT_TABLE_FULL;
        end
        FUNC_DEL: begin
          out_status_d = found ? STAT_OK : STAT_NOT_FOUND;
        end
        FUNC_LOOKUP: begin
          if (found) begin
            out_status_d = STAT_OK;
            out_mac_d    = best_mac;
            out_dev_d    = best_dev;
            out_mtu_d    = mtu_q;
            out_len_d    = best_len;
          end
        end
        default: begin
          out_status_d = STAT_NOT_FOUND;
        end
      endcase
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_mac_q    <= out_mac_d;
    out_dev_q    <= out_dev_d;
    out_mtu_q    <= out_mtu_d;
    out_len_q    <= out_len_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {4'b0000, out_len_q, out_mtu_q, out_dev_q, out_mac_q};

  `ASSERT_CLK(a_busy_after_accept, in_fire |=> !s_axis_tready,
              "slave side still ready after a transaction was taken")
  `ASSERT_CLK(a_result_from_commit, $rose(m_axis_tvalid) |-> $past(ctl.commit),
              "result raised without a commit")
  `ASSERT_CLK(a_add_sets_valid, (ctl.commit && found && op_q == FUNC_ADD) |=>
              valid_q[best_idx], "added entry not marked valid")

endmodule
